// ----- src/axe_pkg.sv -----
// shared types and constants for the ax25 address text encoder
package axe_pkg;

   localparam int ADDR_CHARS = 6;
   localparam int POS_W = 3;

   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [7:0] CHAR_DASH = 8'h2D;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   localparam logic [7:0] PAD_BYTE = 8'h40;
   localparam logic [7:0] SSID_RES = 8'h60;
   localparam logic [7:0] SSID_MAX = 8'h0F;
   localparam logic [POS_W-1:0] SSID_POS = 3'd6;

   typedef logic [7:0] addr_byte_type;

   // one finished destination string, ready to be sent as address bytes
   typedef struct packed {
      logic ok;
      addr_byte_type [ADDR_CHARS-1:0] chars;
      addr_byte_type ssid_field;
   } axe_job_type;

endpackage

// ----- src/axe_if.sv -----
// valid/ready channel interfaces for text input and address output
interface axe_req_if;
   logic valid;
   logic ready;
   logic [7:0] char_code;
   logic end_of_text;
   logic final_address;

   modport source (output valid, output char_code, output end_of_text,
                   output final_address, input ready);
   modport sink (input valid, input char_code, input end_of_text,
                 input final_address, output ready);
endinterface

interface axe_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] address_byte;
   logic [2:0] byte_position;
   logic parse_ok;
   logic last_of_run;

   modport source (output valid, output address_byte, output byte_position,
                   output parse_ok, output last_of_run, input ready);
   modport sink (input valid, input address_byte, input byte_position,
                 input parse_ok, input last_of_run, output ready);
endinterface

// ----- src/axe_scanner.sv -----
// front end: classifies text characters and builds one address job per string
module axe_scanner #(
   parameter int BASE_CHARS = 6,
   parameter int KEPT_LIMIT = 15
) (
   input  logic clock,
   input  logic reset,
   input  logic take,
   input  logic [7:0] char_code,
   input  logic end_of_text,
   input  logic final_address,
   output logic job_push,
   output axe_pkg::axe_job_type job
);
   import axe_pkg::*;

   localparam int KEPT_W = $clog2(KEPT_LIMIT + 1);
   localparam int BLEN_W = $clog2(BASE_CHARS + 2);

   logic [6:0] letters_ff [ADDR_CHARS];
   logic [6:0] letters_in [ADDR_CHARS];
   logic [KEPT_W-1:0] kept_ff, kept_in;
   logic [BLEN_W-1:0] blen_ff, blen_in;
   logic [3:0] ssid_ff, ssid_in;
   logic dash_ff, dash_in;
   logic ovf_ff, ovf_in;
   logic digit_ff, digit_in;
   logic invalid_ff, invalid_in;
   logic stopped_ff, stopped_in;

   logic [7:0] c_up;
   logic is_digit, is_alpha, is_dash, keep;
   logic [7:0] ssid_calc;
   logic ssid_ok;

   always_comb begin
      c_up = char_code;
      if (char_code >= CHAR_LOWER_A && char_code <= CHAR_LOWER_Z) begin
         c_up = char_code - CASE_OFFSET;
      end
      is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
      is_alpha = (c_up >= CHAR_UPPER_A) && (c_up <= CHAR_UPPER_Z);
      is_dash = (char_code == CHAR_DASH);
      keep = !stopped_ff && (char_code != CHAR_NUL) && (is_alpha || is_digit || is_dash)
             && (int'(kept_ff) < KEPT_LIMIT);
      // ssid * 10 + digit, at most 159
      ssid_calc = ({4'd0, ssid_ff} << 3) + ({4'd0, ssid_ff} << 1) + (char_code - CHAR_ZERO);
   end

   always_comb begin
      letters_in = letters_ff;
      kept_in = kept_ff;
      blen_in = blen_ff;
      ssid_in = ssid_ff;
      dash_in = dash_ff;
      ovf_in = ovf_ff;
      digit_in = digit_ff;
      invalid_in = invalid_ff;
      stopped_in = stopped_ff;
      if (!stopped_ff && char_code == CHAR_NUL) begin
         stopped_in = 1'b1;
      end
      if (keep) begin
         kept_in = kept_ff + 1'b1;
         if (!dash_ff) begin
            if (is_dash) begin
               dash_in = 1'b1;
            end else begin
               for (int i = 0; i < ADDR_CHARS; i++) begin
                  if (int'(blen_ff) == i) begin
                     letters_in[i] = c_up[6:0];
                  end
               end
               if (int'(blen_ff) <= BASE_CHARS) begin
                  blen_in = blen_ff + 1'b1;
               end
            end
         end else if (is_digit) begin
            digit_in = 1'b1;
            if (ssid_calc > SSID_MAX) begin
               ovf_in = 1'b1;
            end
            ssid_in = ssid_calc[3:0];
         end else begin
            invalid_in = 1'b1;
         end
      end
   end

   // job assembled from the state including this character
   always_comb begin
      ssid_ok = dash_in && digit_in && !invalid_in && !ovf_in;
      job.ok = (blen_in != '0) && (int'(blen_in) <= BASE_CHARS);
      for (int i = 0; i < ADDR_CHARS; i++) begin
         if (int'(blen_in) > i) begin
            job.chars[i] = {letters_in[i], 1'b0};
         end else begin
            job.chars[i] = PAD_BYTE;
         end
      end
      job.ssid_field = SSID_RES | {3'd0, (ssid_ok ? ssid_in : 4'd0), 1'b0}
                       | {7'd0, final_address};
      job_push = take && end_of_text;
   end

   always_ff @(posedge clock) begin
      if (reset || job_push) begin
         for (int i = 0; i < ADDR_CHARS; i++) begin
            letters_ff[i] <= '0;
         end
         kept_ff <= '0;
         blen_ff <= '0;
         ssid_ff <= '0;
         dash_ff <= 1'b0;
         ovf_ff <= 1'b0;
         digit_ff <= 1'b0;
         invalid_ff <= 1'b0;
         stopped_ff <= 1'b0;
      end else if (take) begin
         letters_ff <= letters_in;
         kept_ff <= kept_in;
         blen_ff <= blen_in;
         ssid_ff <= ssid_in;
         dash_ff <= dash_in;
         ovf_ff <= ovf_in;
         digit_ff <= digit_in;
         invalid_ff <= invalid_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

// ----- src/axe_job_fifo.sv -----
// two-entry queue of address jobs between scanner and emitter
module axe_job_fifo (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  axe_pkg::axe_job_type push_job,
   input  logic pop,
   output logic full,
   output logic empty,
   output axe_pkg::axe_job_type head_job
);
   import axe_pkg::*;

   axe_job_type mem_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head_job = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         priority case ({push, pop})
            2'b10: count_ff <= count_ff + 2'd1;
            2'b01: count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// ----- src/axe_emitter.sv -----
// back end: walks the head job and sends its address bytes or an error
module axe_emitter (
   input  logic clock,
   input  logic reset,
   input  logic job_valid,
   input  axe_pkg::axe_job_type job,
   output logic job_pop,
   axe_rsp_if.source rsp
);
   import axe_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic fire, last;

   always_comb begin
      last = !job.ok || (pos_ff == SSID_POS);
      fire = rsp.valid && rsp.ready;
      job_pop = fire && last;
      rsp.valid = job_valid;
      rsp.last_of_run = last;
      rsp.parse_ok = job.ok;
      rsp.byte_position = job.ok ? pos_ff : '0;
      if (!job.ok) begin
         rsp.address_byte = '0;
      end else if (pos_ff == SSID_POS) begin
         rsp.address_byte = job.ssid_field;
      end else begin
         rsp.address_byte = job.chars[pos_ff];
      end
      pos_in = pos_ff;
      if (fire) begin
         pos_in = last ? '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

// ----- src/ax25_address_text_encoder.sv -----
// top level of the ax25 destination address text encoder
//
//  channel   dir  handshake       payload
//  req_bus   in   valid / ready   char_code, end_of_text, final_address
//  rsp_bus   out  valid / ready   address_byte, byte_position, parse_ok, last_of_run
//
// a character is taken every cycle while the job queue has room; the scanner
// updates its counters in the transfer cycle itself
// each completed string becomes one job; the emitter sends seven bytes, one per
// cycle while the receiver is ready, or one error result
// reset is synchronous and clears scanner state, queue and byte counter
// a stalled output only backs up the two-entry queue; input stalls then
module ax25_address_text_encoder #(
   parameter int BASE_CHARS = 6,
   parameter int KEPT_LIMIT = 15
) (
   input  logic clock,
   input  logic reset,
   axe_req_if.sink req_bus,
   axe_rsp_if.source rsp_bus
);
   import axe_pkg::*;

   logic take;
   logic job_push, job_pop;
   logic q_full, q_empty;
   axe_job_type new_job, head_job;

   // input waits whenever the job queue is full, even for a character that does not finish a string
   assign req_bus.ready = !q_full;
   assign take = req_bus.valid && req_bus.ready;

   axe_scanner #(
      .BASE_CHARS(BASE_CHARS),
      .KEPT_LIMIT(KEPT_LIMIT)
   ) u_scanner (
      .clock(clock),
      .reset(reset),
      .take(take),
      .char_code(req_bus.char_code),
      .end_of_text(req_bus.end_of_text),
      .final_address(req_bus.final_address),
      .job_push(job_push),
      .job(new_job)
   );

   // decouples string parsing from byte-by-byte output
   axe_job_fifo u_fifo (
      .clock(clock),
      .reset(reset),
      .push(job_push),
      .push_job(new_job),
      .pop(job_pop),
      .full(q_full),
      .empty(q_empty),
      .head_job(head_job)
   );

   axe_emitter u_emitter (
      .clock(clock),
      .reset(reset),
      .job_valid(!q_empty),
      .job(head_job),
      .job_pop(job_pop),
      .rsp(rsp_bus)
   );

endmodule

// ----- bench/axe_score_pkg.sv -----
`timescale 1ns / 1ps
// scoreboard class: address predictor and in-order result checker
package axe_score_pkg;
   import axe_pkg::*;

   typedef struct {
      logic [7:0] address_byte;
      logic [POS_W-1:0] byte_position;
      logic parse_ok;
      logic last_of_run;
   } addr_out_type;

   class address_scoreboard;
      int base_chars;
      int kept_limit;
      logic [6:0] base_letters [ADDR_CHARS];
      int kept_count;
      int base_length;
      bit dash_found;
      bit ssid_overflow;
      bit digit_seen;
      bit ssid_invalid;
      bit scan_stopped;
      logic [3:0] ssid_value;
      addr_out_type pending_bytes [$];
      int error_count;

      function new(int base_chars, int kept_limit);
         this.base_chars = base_chars;
         this.kept_limit = kept_limit;
         error_count = 0;
         clear_scan();
      endfunction

      function void clear_scan();
         foreach (base_letters[i]) base_letters[i] = '0;
         kept_count = 0;
         base_length = 0;
         dash_found = 0;
         ssid_overflow = 0;
         digit_seen = 0;
         ssid_invalid = 0;
         scan_stopped = 0;
         ssid_value = '0;
      endfunction

      // classify one byte and update the callsign scan state
      function void scan_char(logic [7:0] code);
         logic [7:0] c;
         bit is_digit;
         bit is_alpha;
         int v;
         c = code;
         is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
         if ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) c = c - CASE_OFFSET;
         is_alpha = (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z);
         if (!(is_alpha || is_digit || (c == CHAR_DASH))) return;
         if (kept_count >= kept_limit) return;
         kept_count++;
         if (!dash_found) begin
            if (c == CHAR_DASH) begin
               dash_found = 1;
            end else begin
               if (base_length < ADDR_CHARS) base_letters[base_length] = c[6:0];
               if (base_length <= base_chars) base_length++;
            end
         end else if (is_digit) begin
            v = int'(ssid_value) * 10 + int'(c - CHAR_ZERO);
            digit_seen = 1;
            if (v > int'(SSID_MAX)) ssid_overflow = 1;
            ssid_value = 4'(v);
         end else begin
            ssid_invalid = 1;
         end
      endfunction

      // one accepted input transfer; queues the address bytes it causes
      function void note_char(logic [7:0] code, logic eot, logic fin);
         addr_out_type r;
         logic [3:0] ssid;
         if (!scan_stopped) begin
            if (code == CHAR_NUL) scan_stopped = 1;
            else scan_char(code);
         end
         if (!eot) return;
         if ((base_length == 0) || (base_length > base_chars)) begin
            r.address_byte = '0;
            r.byte_position = '0;
            r.parse_ok = 1'b0;
            r.last_of_run = 1'b1;
            pending_bytes.push_back(r);
         end else begin
            ssid = (dash_found && digit_seen && !ssid_invalid && !ssid_overflow)
                   ? ssid_value : 4'd0;
            for (int i = 0; i < ADDR_CHARS; i++) begin
               r.address_byte = (i < base_length) ? {base_letters[i], 1'b0} : PAD_BYTE;
               r.byte_position = POS_W'(i);
               r.parse_ok = 1'b1;
               r.last_of_run = 1'b0;
               pending_bytes.push_back(r);
            end
            r.address_byte = SSID_RES | {3'b000, ssid, fin};
            r.byte_position = SSID_POS;
            r.parse_ok = 1'b1;
            r.last_of_run = 1'b1;
            pending_bytes.push_back(r);
         end
         clear_scan();
      endfunction

      task report_mismatch(string what);
         error_count++;
         $display("%0t mismatch: %s", $realtime, what);
      endtask

      task check_byte(logic [7:0] addr, logic [POS_W-1:0] pos, logic ok, logic last);
         addr_out_type want;
         if (pending_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected result byte %02h pos %0d", addr, pos));
            return;
         end
         want = pending_bytes.pop_front();
         if (addr !== want.address_byte)
            report_mismatch($sformatf("address_byte %02h, want %02h (pos %0d)",
                                      addr, want.address_byte, want.byte_position));
         if (pos !== want.byte_position)
            report_mismatch($sformatf("byte_position %0d, want %0d", pos, want.byte_position));
         if (ok !== want.parse_ok)
            report_mismatch($sformatf("parse_ok %b, want %b", ok, want.parse_ok));
         if (last !== want.last_of_run)
            report_mismatch($sformatf("last_of_run %b, want %b", last, want.last_of_run));
      endtask

      task leftover_check();
         if (pending_bytes.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_bytes.size()));
      endtask
   endclass

endpackage

// ----- bench/tb_ax25_address_text_encoder.sv -----
`timescale 1ns / 1ps
// top level bench for the ax25 address text encoder
module tb_ax25_address_text_encoder;
   import axe_pkg::*;
   import axe_score_pkg::*;

   localparam int BASE_CHARS = 6;
   localparam int KEPT_LIMIT = 15;
   localparam int RANDOM_ITEMS = 125;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 20;
   // receiver hold-off long enough to fill the job queue and stall the input
   localparam int LONG_HOLD = 120;
   localparam int HOLD_AFTER = 40;

   typedef logic [7:0] char_q_type [$];

   logic clock;
   logic reset;

   axe_req_if req_bus ();
   axe_rsp_if rsp_bus ();

   ax25_address_text_encoder #(
      .BASE_CHARS(BASE_CHARS),
      .KEPT_LIMIT(KEPT_LIMIT)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   address_scoreboard sb = new(BASE_CHARS, KEPT_LIMIT);

   int results_seen = 0;
   int random_items = 0;
   int cycle_count = 0;

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   function automatic char_q_type text_bytes(string s);
      char_q_type q;
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
      return q;
   endfunction

   // a letter or digit, letters in random case
   function automatic logic [7:0] random_alnum();
      logic [7:0] c;
      if ($urandom_range(0, 9) < 3) return CHAR_ZERO + 8'($urandom_range(0, 9));
      c = CHAR_UPPER_A + 8'($urandom_range(0, 25));
      if ($urandom_range(0, 1)) c = c + CASE_OFFSET;
      return c;
   endfunction

   // mostly well-formed callsigns with random content, the rest long or junk text
   function automatic char_q_type random_callsign();
      char_q_type q;
      int kind;
      int blen;
      int ssid;
      int sub;
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
         blen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 9) : $urandom_range(1, 6);
         repeat (blen) q.push_back(random_alnum());
         if ($urandom_range(0, 3) != 0) begin
            q.push_back(CHAR_DASH);
            sub = $urandom_range(0, 9);
            if (sub < 6) begin
               // legal ssid, sometimes with a leading zero
               ssid = $urandom_range(0, 15);
               if ($urandom_range(0, 4) == 0) q.push_back(CHAR_ZERO);
               if (ssid >= 10) q.push_back(CHAR_ZERO + 8'(ssid / 10));
               q.push_back(CHAR_ZERO + 8'(ssid % 10));
            end else if (sub == 6) begin
               // ssid too large
               ssid = $urandom_range(16, 99);
               q.push_back(CHAR_ZERO + 8'(ssid / 10));
               q.push_back(CHAR_ZERO + 8'(ssid % 10));
            end else if (sub == 8) begin
               // a digit followed by a letter or a second dash
               q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
               q.push_back($urandom_range(0, 1) ? CHAR_DASH : CHAR_UPPER_A + 8'(sub));
            end else if (sub == 9) begin
               repeat ($urandom_range(3, 8)) q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
            end
            // sub 7: dash with nothing after it
         end
         if ($urandom_range(0, 9) == 0) begin
            // zero byte, then bytes that must be ignored
            q.push_back(CHAR_NUL);
            repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range(0, 255)));
         end
      end else if (kind == 7) begin
         // long text, usually running into the kept-character limit
         blen = $urandom_range(14, 20);
         sub = $urandom_range(1, 7);
         for (int i = 0; i < blen; i++)
            q.push_back((i == sub) ? CHAR_DASH : random_alnum());
      end else begin
         // raw byte noise
         blen = $urandom_range(1, 12);
         repeat (blen) q.push_back(($urandom_range(0, 7) == 0) ? CHAR_DASH
                                                               : 8'($urandom_range(0, 255)));
      end
      return q;
   endfunction

   // offer one byte and wait for its transfer; ready is looked at on the
   // falling edge so the decision is settled before the accepting rising edge
   task automatic send_char(logic [7:0] code, logic eot, logic fin, bit steady);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.char_code <= code;
      req_bus.end_of_text <= eot;
      req_bus.final_address <= fin;
      do @(negedge clock); while (!req_bus.ready);
      sb.note_char(code, eot, fin);
      @(posedge clock);
   endtask

   // one destination string; final_address is random on the non-final bytes
   task automatic send_text(char_q_type text, logic fin, bit steady);
      for (int i = 0; i < text.size(); i++) begin
         if (i == text.size() - 1) send_char(text[i], 1'b1, fin, steady);
         else send_char(text[i], 1'b0, 1'($urandom_range(0, 1)), steady);
      end
   endtask

   // main stimulus
   initial begin
      char_q_type q;
      bit steady;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.char_code = '0;
      req_bus.end_of_text = 1'b0;
      req_bus.final_address = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty string: lone zero byte closing the text
      q = '{CHAR_NUL};
      send_text(q, 1'b1, 1'b0);
      // lower case base, largest ssid, extension bit set
      send_text(text_bytes("z-15"), 1'b1, 1'b0);
      // dash first means empty base
      send_text(text_bytes("-1"), 1'b0, 1'b0);
      // base one character too long
      send_text(text_bytes("ABCDEFG"), 1'b1, 1'b0);
      // ssid above fifteen falls back to zero
      send_text(text_bytes("9a-16"), 1'b0, 1'b1);
      // letter after the ssid digits makes the ssid unusable
      send_text(text_bytes("Q-1x"), 1'b1, 1'b0);
      // bytes after a zero byte are ignored, top-bit byte included
      q = '{8'h4B, CHAR_NUL, 8'hFF};
      send_text(q, 1'b0, 1'b0);

      // random strings; some go through with no gaps at all
      while (random_items < RANDOM_ITEMS) begin
         q = random_callsign();
         steady = ($urandom_range(0, 3) == 0);
         send_text(q, 1'($urandom_range(0, 1)), steady);
         random_items += q.size();
      end
      req_bus.valid <= 1'b0;

      // let the queue and emitter drain, then a short quiet window
      while (sb.pending_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.leftover_check();
      if (sb.error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // receiver: bursts of ready with random stalls, and one long hold-off
   // while the sender keeps offering so the block backs up and stalls its input
   initial begin
      int gap;
      bit held;
      held = 0;
      rsp_bus.ready = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (!held && (results_seen >= HOLD_AFTER)) begin
            held = 1;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // result monitor: a transfer seen on the falling edge completes at the next rising edge
   always @(negedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         sb.check_byte(rsp_bus.address_byte, rsp_bus.byte_position,
                       rsp_bus.parse_ok, rsp_bus.last_of_run);
         results_seen++;
      end
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
